>>> design/apg_pkg.sv
// Package for the arc polyline generator: widths, controller state codes,
// command/status structs and the CORDIC arctangent table. No dependencies.
package apg_pkg;

    localparam int LEN_W     = 20;
    localparam int CURV_W    = 24;
    localparam int HEAD_W    = 16;
    localparam int PPL_W     = 16;
    localparam int COORD_W   = 21;
    localparam int PPL_RESET = 256;
    localparam int MAX_POINTS_DEF   = 63;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int DIV_STEPS        = 35;   // quotient bits of |sweep| >> 8
    localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam int CW = 34;   // CORDIC x/y width
    localparam int ZW = 34;   // CORDIC angle width
    localparam int ACC_W = 34;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_ORIG  = 3'd2;
    localparam logic [2:0] ST_ROT   = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    typedef struct packed {
        logic load;       // capture item, start division
        logic div_step;   // one quotient bit for both divisions
        logic rot_start;  // load CORDIC for next vertex
        logic rot_step;   // one CORDIC iteration
        logic mul;        // multiply seg by cos/sin
        logic acc;        // accumulate and register output vertex
        logic orig;       // register origin vertex
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic rot_done;
        logic last_vtx;
    } t_sts;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:  atan_turn = 32'h20000000;  5'd1:  atan_turn = 32'h12E4051D;
            5'd2:  atan_turn = 32'h09FB385B;  5'd3:  atan_turn = 32'h051111D4;
            5'd4:  atan_turn = 32'h028B0D43;  5'd5:  atan_turn = 32'h0145D7E1;
            5'd6:  atan_turn = 32'h00A2F61E;  5'd7:  atan_turn = 32'h00517C55;
            5'd8:  atan_turn = 32'h0028BE53;  5'd9:  atan_turn = 32'h00145F2E;
            5'd10: atan_turn = 32'h000A2F98;  5'd11: atan_turn = 32'h000517CC;
            5'd12: atan_turn = 32'h00028BE6;  5'd13: atan_turn = 32'h000145F3;
            5'd14: atan_turn = 32'h0000A2F9;  5'd15: atan_turn = 32'h0000517C;
            5'd16: atan_turn = 32'h000028BE;  5'd17: atan_turn = 32'h0000145F;
            5'd18: atan_turn = 32'h00000A2F;  5'd19: atan_turn = 32'h00000517;
            5'd20: atan_turn = 32'h0000028B;  5'd21: atan_turn = 32'h00000145;
            5'd22: atan_turn = 32'h000000A2;  5'd23: atan_turn = 32'h00000051;
            default: atan_turn = 32'h0;
        endcase
    endfunction

endpackage

>>> design/arc_polyline_generator_top.sv
// Arc polyline generator: one arc in, n+1 vertices out (origin first), where
// n = clamp(points_per_length * arc_length >> 16, 2, MAX_POINTS). After an
// arc is accepted, bit-serial division produces the segment length and
// per-segment turn, and the origin vertex is then registered; each vertex
// then takes CORDIC_STEPS iterations in the shared CORDIC unit followed by
// a multiply and an accumulate step. One arc is in work at a time.
// Depends on apg_pkg, apg_ctrl, apg_dp.
module arc_polyline_generator_top #(
    parameter int MAX_POINTS   = apg_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = apg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [apg_pkg::PPL_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [apg_pkg::LEN_W-1:0]          i_arc_length,
    input  logic signed [apg_pkg::CURV_W-1:0]  i_curvature,
    input  logic [apg_pkg::HEAD_W-1:0]         i_start_heading,
    input  logic                               i_turn_positive,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [apg_pkg::COORD_W-1:0] o_point_x,
    output logic signed [apg_pkg::COORD_W-1:0] o_point_y,
    output logic                               o_last_point
);

    logic [apg_pkg::PPL_W-1:0] r_ppl;
    apg_pkg::t_cmd cmd;
    apg_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppl <= apg_pkg::PPL_W'(apg_pkg::PPL_RESET);
        end else if (i_cfg_valid) begin
            r_ppl <= i_cfg_data;
        end
    end

    apg_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_sts(sts), .o_cmd(cmd)
    );

    apg_dp #(.MAX_POINTS(MAX_POINTS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk, .i_ppl(r_ppl), .i_arc_length, .i_curvature, .i_start_heading,
        .i_turn_positive, .i_cmd(cmd), .o_sts(sts), .o_point_x, .o_point_y,
        .o_last_point
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.rot_step, cmd.mul, cmd.acc}))
        else $error("conflicting datapath commands");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_point_x))
        else $error("stalled vertex changed");
    a_rot_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul |-> sts.rot_done)
        else $error("multiply before CORDIC finished");

endmodule

>>> design/apg_ctrl.sv
// Controller state machine of the arc polyline generator.
// Depends on apg_pkg for state codes and command/status structs.
module apg_ctrl #(
    parameter int CORDIC_STEPS = apg_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  apg_pkg::t_sts i_sts,
    output apg_pkg::t_cmd o_cmd
);

    localparam int CNT_W = 6;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;
    logic             r_ovalid, n_ovalid;
    logic             take;

    assign take        = r_ovalid && i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_in_ready  = (r_state == apg_pkg::ST_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        case (r_state)
            apg_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = apg_pkg::ST_DIV;
                end
            end
            apg_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(apg_pkg::DIV_STEPS - 1)) begin
                    n_state = apg_pkg::ST_ORIG;
                end
            end
            apg_pkg::ST_ORIG: begin
                if (!r_ovalid || take) begin
                    o_cmd.orig = 1'b1;
                    n_ovalid   = 1'b1;
                    o_cmd.rot_start = 1'b1;
                    n_cnt   = '0;
                    n_state = apg_pkg::ST_ROT;
                end
            end
            apg_pkg::ST_ROT: begin
                o_cmd.rot_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = apg_pkg::ST_MUL;
                end
            end
            apg_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_last    = i_sts.last_vtx;
                n_state   = apg_pkg::ST_EMIT;
            end
            apg_pkg::ST_EMIT: begin
                if (!r_ovalid || take) begin
                    o_cmd.acc = 1'b1;
                    n_ovalid  = 1'b1;
                    if (r_last) begin
                        n_state = apg_pkg::ST_IDLE;
                    end else begin
                        o_cmd.rot_start = 1'b1;
                        n_cnt   = '0;
                        n_state = apg_pkg::ST_ROT;
                    end
                end
            end
            default: n_state = apg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= apg_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

>>> design/apg_dp.sv
// Datapath of the arc polyline generator: segment count, restoring dividers,
// CORDIC unit, multipliers and vertex accumulators. Depends on apg_pkg.
module apg_dp #(
    parameter int MAX_POINTS   = apg_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = apg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic [apg_pkg::PPL_W-1:0]           i_ppl,
    input  logic [apg_pkg::LEN_W-1:0]           i_arc_length,
    input  logic signed [apg_pkg::CURV_W-1:0]   i_curvature,
    input  logic [apg_pkg::HEAD_W-1:0]          i_start_heading,
    input  logic                                i_turn_positive,
    input  apg_pkg::t_cmd                       i_cmd,
    output apg_pkg::t_sts                       o_sts,
    output logic signed [apg_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [apg_pkg::COORD_W-1:0]  o_point_y,
    output logic                                o_last_point
);

    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int DW  = apg_pkg::DIV_STEPS;   // dividend width of |sweep| >> 8
    localparam int MW  = 44;          // |sweep| width
    localparam int CW  = apg_pkg::CW;
    localparam int ZW  = apg_pkg::ZW;
    localparam int AW  = apg_pkg::ACC_W;
    localparam logic signed [AW-1:0] CMAX = AW'(1048575);
    localparam logic signed [AW-1:0] CMIN = -AW'(1048576);

    // Item registers
    logic [NW-1:0]               r_n;
    logic [NW-1:0]               r_k;
    logic [apg_pkg::HEAD_W-1:0]  r_head;
    logic                        r_neg;
    // Divisions: seg = len / n ; mag = |sweep| / (n*256), one bit per cycle each
    logic [MW-1:0]               r_mrem;
    logic [DW-1:0]               r_mq;
    logic [apg_pkg::LEN_W-1:0]   r_lrem, r_seg;
    logic [5:0]                  r_dbit;
    logic [apg_pkg::HEAD_W-1:0]  r_step;
    // CORDIC
    logic signed [CW-1:0]        r_cx, r_cy;
    logic signed [ZW-1:0]        r_cz;
    logic                        r_flip;
    logic [4:0]                  r_ci;
    // Products
    logic signed [55:0]          r_px, r_py;
    logic signed [AW-1:0]        r_ax, r_ay;

    logic [apg_pkg::PPL_W+apg_pkg::LEN_W-1:0] nprod;
    logic [apg_pkg::PPL_W+apg_pkg::LEN_W-17:0] nraw;
    logic [NW-1:0]               nclamp;
    logic signed [MW:0]          sweep;
    logic [MW-1:0]               sweep_mag;

    assign nprod = i_ppl * i_arc_length;
    assign nraw  = nprod[apg_pkg::PPL_W+apg_pkg::LEN_W-1:16];
    assign sweep = (MW+1)'($signed({1'b0, i_arc_length})) * (MW+1)'(i_curvature);
    assign sweep_mag = sweep[MW] ? MW'(-sweep) : MW'(sweep);

    always_comb begin
        if (nraw < 2) nclamp = NW'(2);
        else if (nraw > MAX_POINTS) nclamp = NW'(MAX_POINTS);
        else nclamp = NW'(nraw);
    end

    // Restoring division step: remainder/quotient shift. (|sweep| >> 8) / n
    // equals |sweep| / (n*256) truncated; the dividend is below 2^35.
    logic [MW-1:0] mtrial;
    logic [apg_pkg::LEN_W:0] ltrial;
    logic [MW-1:0] mrem_sh;
    logic [apg_pkg::LEN_W:0] lrem_sh;
    logic [apg_pkg::HEAD_W-1:0] qlow;

    // mq holds dividend bits shifted out; remainder builds up from MSB.
    assign mrem_sh = {r_mrem[MW-2:0], r_mq[DW-1]};
    assign mtrial  = mrem_sh - MW'(r_n);
    assign lrem_sh = {r_lrem, r_seg[apg_pkg::LEN_W-1]};
    assign ltrial  = lrem_sh - (apg_pkg::LEN_W+1)'(r_n);
    assign qlow    = {r_mq[14:0], !mtrial[MW-1]};

    // CORDIC step
    logic signed [CW-1:0] xs, ys;
    logic [31:0]          at;
    logic [31:0]          u;
    logic                 qflip;
    assign xs = r_cx >>> r_ci;
    assign ys = r_cy >>> r_ci;
    assign at = apg_pkg::atan_turn(r_ci);

    logic [apg_pkg::HEAD_W-1:0] hnext;
    assign hnext = r_head + r_step;
    assign qflip = (hnext[15:14] == 2'd1) || (hnext[15:14] == 2'd2);
    assign u     = {hnext ^ {qflip, 15'd0}, 16'd0};

    logic signed [CW-1:0] cosv, sinv;
    assign cosv = r_flip ? -r_cx : r_cx;
    assign sinv = r_flip ? -r_cy : r_cy;

    logic signed [AW-1:0] nx, ny;
    assign nx = r_ax + AW'((r_px + 56'sd536870912) >>> 30);
    assign ny = r_ay + AW'((r_py + 56'sd536870912) >>> 30);

    function automatic logic signed [apg_pkg::COORD_W-1:0] sat(input logic signed [AW-1:0] v);
        if (v > CMAX) sat = apg_pkg::COORD_W'(CMAX);
        else if (v < CMIN) sat = apg_pkg::COORD_W'(CMIN);
        else sat = apg_pkg::COORD_W'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= nclamp;
            r_k    <= '0;
            r_head <= i_start_heading;
            r_neg  <= sweep[MW] ^ i_turn_positive;
            r_mrem <= '0;
            r_mq   <= DW'(sweep_mag >> 8);
            r_lrem <= '0;
            r_seg  <= i_arc_length;
            r_dbit <= '0;
        end
        if (i_cmd.div_step) begin
            r_dbit <= r_dbit + 1'b1;
            if (!mtrial[MW-1]) begin
                r_mrem <= mtrial;
                r_mq   <= {r_mq[DW-2:0], 1'b1};
            end else begin
                r_mrem <= mrem_sh;
                r_mq   <= {r_mq[DW-2:0], 1'b0};
            end
            if (r_dbit < 6'(apg_pkg::LEN_W)) begin
                if (!ltrial[apg_pkg::LEN_W]) begin
                    r_lrem <= ltrial[apg_pkg::LEN_W-1:0];
                    r_seg  <= {r_seg[apg_pkg::LEN_W-2:0], 1'b1};
                end else begin
                    r_lrem <= lrem_sh[apg_pkg::LEN_W-1:0];
                    r_seg  <= {r_seg[apg_pkg::LEN_W-2:0], 1'b0};
                end
            end
            if (r_dbit == 6'(DW - 1)) begin
                r_step <= r_neg ? apg_pkg::HEAD_W'(0) - qlow : qlow;
            end
        end
        if (i_cmd.orig) begin
            r_ax <= '0;
            r_ay <= '0;
            o_point_x    <= '0;
            o_point_y    <= '0;
            o_last_point <= 1'b0;
        end
        if (i_cmd.rot_start) begin
            r_head <= hnext;
            r_k    <= r_k + 1'b1;
            r_flip <= qflip;
            r_cx   <= apg_pkg::INV_GAIN_Q30;
            r_cy   <= '0;
            r_cz   <= ZW'($signed(u));
            r_ci   <= '0;
        end
        if (i_cmd.rot_step) begin
            r_ci <= r_ci + 1'b1;
            if (!r_cz[ZW-1]) begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - ZW'(at);
            end else begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + ZW'(at);
            end
        end
        if (i_cmd.mul) begin
            r_px <= 56'($signed({1'b0, r_seg})) * 56'(cosv);
            r_py <= 56'($signed({1'b0, r_seg})) * 56'(sinv);
        end
        if (i_cmd.acc) begin
            r_ax <= nx;
            r_ay <= ny;
            o_point_x    <= sat(nx);
            o_point_y    <= sat(ny);
            o_last_point <= (r_k == r_n);
        end
    end

    assign o_sts.div_done = (r_dbit == 6'(DW));
    assign o_sts.rot_done = (r_ci == 5'(CORDIC_STEPS));
    assign o_sts.last_vtx = (r_k == r_n);

endmodule

>>> tb/sv/arc_polyline_generator_top_tb.sv
// Testbench for arc_polyline_generator_top: directed arcs, then random arcs under
// several points-per-length settings, checked vertex by vertex against a local
// fixed-point arc predictor or all-zero vertices. Depends on apg_pkg and the RTL.
module arc_polyline_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_MAX = 63;
    localparam int ROT_ITERS = 16;
    localparam int STALL_LIMIT = 20000;
    localparam longint GAIN_START = 64'sd652032874;
    localparam logic [31:0] ANGLE_LUT [0:15] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    typedef struct packed {
        logic signed [apg_pkg::COORD_W-1:0] x;
        logic signed [apg_pkg::COORD_W-1:0] y;
        logic                               last;
    } t_vertex;

    typedef struct {
        logic [apg_pkg::LEN_W-1:0]         len;
        logic signed [apg_pkg::CURV_W-1:0] curv;
        logic [apg_pkg::HEAD_W-1:0]        head;
        logic                              tp;
        bit                                typed;
    } t_arc;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [apg_pkg::PPL_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [apg_pkg::LEN_W-1:0] i_arc_length = '0;
    logic signed [apg_pkg::CURV_W-1:0] i_curvature = '0;
    logic [apg_pkg::HEAD_W-1:0] i_start_heading = '0;
    logic i_turn_positive = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [apg_pkg::COORD_W-1:0] o_point_x;
    logic signed [apg_pkg::COORD_W-1:0] o_point_y;
    logic o_last_point;

    arc_polyline_generator_top dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_vertex vertex_q[$];
    logic [apg_pkg::PPL_W-1:0] ppl_model = apg_pkg::PPL_W'(apg_pkg::PPL_RESET);
    int mismatches = 0;
    int out_hold_left = 0;
    bit no_gaps = 1'b0;
    int quiet_cycles = 0;

    function automatic logic signed [apg_pkg::COORD_W-1:0] clip_coord(longint v);
        if (v > 1048575) v = 1048575;
        if (v < -1048576) v = -1048576;
        return v[apg_pkg::COORD_W-1:0];
    endfunction

    function automatic void rotate_heading(logic [15:0] h, output longint c,
                                           output longint s);
        logic [31:0] u;
        bit flip;
        longint xr, yr, z, xs, ys;
        u = {h, 16'h0};
        flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
        if (flip) u = u - 32'h80000000;
        xr = GAIN_START;
        yr = 0;
        z = longint'(signed'(u));
        for (int i = 0; i < ROT_ITERS; i++) begin
            xs = xr >>> i;
            ys = yr >>> i;
            if (z >= 0) begin
                xr = xr - ys;
                yr = yr + xs;
                z = z - longint'(ANGLE_LUT[i]);
            end else begin
                xr = xr + ys;
                yr = yr - xs;
                z = z + longint'(ANGLE_LUT[i]);
            end
        end
        c = flip ? -xr : xr;
        s = flip ? -yr : yr;
    endfunction

    function automatic void predict_arc(t_arc a);
        longint n, seg, sweep, mag, xa, ya, c, s;
        bit neg;
        logic [15:0] turn, h;
        t_vertex v;
        n = (longint'(ppl_model) * longint'(a.len)) >>> 16;
        if (n < 2) n = 2;
        if (n > N_MAX) n = N_MAX;
        seg = longint'(a.len) / n;
        sweep = longint'(a.len) * longint'(a.curv);
        neg = sweep < 0;
        mag = (neg ? -sweep : sweep) / (n * 256);
        if (a.tp) neg = !neg;
        turn = neg ? 16'(-mag) : 16'(mag);
        xa = 0;
        ya = 0;
        v = '{x: '0, y: '0, last: 1'b0};
        vertex_q.push_back(v);
        for (int k = 1; k <= n; k++) begin
            h = a.head + 16'(k) * turn;
            rotate_heading(h, c, s);
            xa = xa + ((seg * c + (64'sd1 <<< 29)) >>> 30);
            ya = ya + ((seg * s + (64'sd1 <<< 29)) >>> 30);
            v.x = clip_coord(xa);
            v.y = clip_coord(ya);
            v.last = (k == n);
            vertex_q.push_back(v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || out_hold_left > 0) begin
            i_out_ready <= 1'b0;
            if (out_hold_left > 0) out_hold_left <= out_hold_left - 1;
        end else begin
            i_out_ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (vertex_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex x=%0d y=%0d last=%0b",
                             o_point_x, o_point_y, o_last_point);
            end else begin
                e = vertex_q.pop_front();
                if (e.x !== o_point_x || e.y !== o_point_y || e.last !== o_last_point) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch: exp x=%0d y=%0d last=%0b, %s",
                                 e.x, e.y, e.last,
                                 $sformatf("got x=%0d y=%0d last=%0b",
                                           o_point_x, o_point_y, o_last_point));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL arc_polyline_generator_top");
            $finish;
        end
    end

    task automatic write_ppl(logic [apg_pkg::PPL_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        ppl_model = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_arc(t_arc a);
        i_in_valid <= 1'b1;
        i_arc_length <= a.len;
        i_curvature <= a.curv;
        i_start_heading <= a.head;
        i_turn_positive <= a.tp;
        do @(posedge i_clk); while (!o_in_ready);
        if (a.typed) begin
            vertex_q.push_back('{x: '0, y: '0, last: 1'b0});
            vertex_q.push_back('{x: '0, y: '0, last: 1'b0});
            vertex_q.push_back('{x: '0, y: '0, last: 1'b1});
        end else begin
            predict_arc(a);
        end
        if (!no_gaps && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (vertex_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    t_arc directed[] = '{
        '{20'd0, 24'sd0, 16'h0000, 1'b0, 1'b1},
        '{20'd0, 24'sh7FFFFF, 16'hFFFF, 1'b1, 1'b1},
        '{20'd0, -24'sh800000, 16'h8000, 1'b0, 1'b1},
        '{20'd1, 24'sd1000, 16'h4000, 1'b0, 1'b0},
        '{20'd511, 24'sd0, 16'h0000, 1'b0, 1'b0},
        '{20'd768, 24'sd300, 16'h4000, 1'b0, 1'b0},
        '{20'd768, 24'sd300, 16'h4000, 1'b1, 1'b0},
        '{20'd2560, -24'sd300, 16'h8000, 1'b0, 1'b0},
        '{20'd2560, 24'sd4096, 16'hC000, 1'b1, 1'b0},
        '{20'hFFFFF, 24'sd0, 16'h0000, 1'b0, 1'b0},
        '{20'hFFFFF, 24'sd0, 16'h4000, 1'b0, 1'b0},
        '{20'hFFFFF, 24'sd0, 16'h8000, 1'b0, 1'b0},
        '{20'hFFFFF, 24'sd0, 16'hC000, 1'b0, 1'b0},
        '{20'hFFFFF, 24'sd0, 16'hFFFF, 1'b0, 1'b0},
        '{20'hFFFFF, 24'sh7FFFFF, 16'h2000, 1'b0, 1'b0},
        '{20'hFFFFF, -24'sh800000, 16'h6000, 1'b1, 1'b0},
        '{20'h80000, 24'sd65536, 16'hA000, 1'b0, 1'b0},
        '{20'd16128, -24'sd1, 16'hE000, 1'b1, 1'b0}
    };

    logic [apg_pkg::PPL_W-1:0] phase_ppl[6] =
        '{16'd0, 16'hFFFF, 16'd256, 16'd1, 16'd4096, 16'd0};
    t_arc a;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) send_arc(directed[i]);
        drain_results();
        phase_ppl[5] = 16'($urandom);
        for (int p = 0; p < 6; p++) begin
            write_ppl(phase_ppl[p]);
            no_gaps = (p == 2);
            if (p == 1) out_hold_left = 3000;
            for (int j = 0; j < 70; j++) begin
                a.len = 20'($urandom) & 20'((1 << $urandom_range(1, 20)) - 1);
                if (ppl_model > 16'd4096 && $urandom_range(0, 3) != 0)
                    a.len = 20'($urandom_range(0, 255));
                a.curv = 24'($urandom);
                if ($urandom_range(0, 3) == 0) a.curv = a.curv >>> $urandom_range(1, 20);
                a.head = 16'($urandom);
                a.tp = 1'($urandom_range(0, 1));
                a.typed = 1'b0;
                send_arc(a);
            end
            drain_results();
        end
        if (mismatches == 0)
            $display("PASS arc_polyline_generator_top");
        else
            $display("FAIL arc_polyline_generator_top");
        $finish;
    end
endmodule
